FILE: sv/tfpc_pkg.sv
// ----------------------------------------------------------------------------
// tfpc_pkg
// Shared types and constants of the thermostat fan PWM controller.
// ----------------------------------------------------------------------------
package tfpc_pkg;

  localparam int unsigned SampleW   = 12;
  localparam int unsigned GainW     = 8;
  localparam int unsigned HoldW     = 16;
  localparam int unsigned SetpointW = 7;
  localparam int unsigned TempW     = 8;
  localparam int unsigned CompareW  = 16;
  localparam int unsigned PerTickW  = 10;
  localparam int unsigned TicksW    = 6;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [SetpointW-1:0] SetpointMax   = 7'd127;
  localparam logic [SetpointW-1:0] SetpointReset = 7'd20;
  localparam logic [TicksW-1:0]    TicksMax      = 6'd50;
  localparam logic [TempW-1:0]     DiffSat       = 8'd10;

  localparam logic [HoldW-1:0]    HoldReset    = 16'd1000;
  localparam logic [GainW-1:0]    GainReset    = 8'd82;
  localparam logic [CompareW-1:0] BaseReset    = 16'd4199;
  localparam logic [PerTickW-1:0] PerTickReset = 10'd84;

  localparam logic [CfgIdxW-1:0] RegHoldCount     = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSensorGain    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegBaseCompare   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegComparePerTick = 2'd3;

  typedef struct packed {
    logic up;
    logic down;
  } btn_t;

  typedef struct packed {
    logic [PerTickW-1:0] per_tick;
    logic [CompareW-1:0] base;
  } duty_cfg_t;

endpackage

FILE: sv/tfpc_hold.sv
// ----------------------------------------------------------------------------
// tfpc_hold
// Button hold counters and the saturating setpoint register.
// ----------------------------------------------------------------------------
module tfpc_hold (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               adv_i,
  input  tfpc_pkg::btn_t                     btn_i,
  input  logic [tfpc_pkg::HoldW-1:0]         hold_count_i,
  output logic [tfpc_pkg::SetpointW-1:0]     setpoint_o
);

  logic [tfpc_pkg::HoldW-1:0]     up_cnt_q, up_cnt_d, dn_cnt_q, dn_cnt_d;
  logic [tfpc_pkg::HoldW-1:0]     up_raw, dn_raw;
  logic                           up_last_q, dn_last_q;
  logic                           up_fire, dn_fire;
  logic [tfpc_pkg::SetpointW-1:0] sp_q, sp_d, sp_mid;

  always_comb begin
    if (!btn_i.up) begin
      up_raw = '0;
    end else if (up_last_q) begin
      up_raw = up_cnt_q + 1'b1;
    end else begin
      up_raw = up_cnt_q;
    end
    if (!btn_i.down) begin
      dn_raw = '0;
    end else if (dn_last_q) begin
      dn_raw = dn_cnt_q + 1'b1;
    end else begin
      dn_raw = dn_cnt_q;
    end
    up_fire  = (hold_count_i != '0) && (up_raw == hold_count_i);
    dn_fire  = (hold_count_i != '0) && (dn_raw == hold_count_i);
    up_cnt_d = up_fire ? '0 : up_raw;
    dn_cnt_d = dn_fire ? '0 : dn_raw;
    sp_mid   = (up_fire && sp_q < tfpc_pkg::SetpointMax) ? sp_q + 1'b1 : sp_q;
    sp_d     = (dn_fire && sp_mid != '0) ? sp_mid - 1'b1 : sp_mid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_cnt_q  <= '0;
      dn_cnt_q  <= '0;
      up_last_q <= 1'b0;
      dn_last_q <= 1'b0;
      sp_q      <= tfpc_pkg::SetpointReset;
    end else if (adv_i) begin
      up_cnt_q  <= up_cnt_d;
      dn_cnt_q  <= dn_cnt_d;
      up_last_q <= btn_i.up;
      dn_last_q <= btn_i.down;
      sp_q      <= sp_d;
    end
  end

  assign setpoint_o = sp_d;

endmodule

FILE: sv/tfpc_duty.sv
// ----------------------------------------------------------------------------
// tfpc_duty
// Fan compare value from temperature, setpoint and duty registers.
// ----------------------------------------------------------------------------
module tfpc_duty (
  input  logic [tfpc_pkg::TempW-1:0]     temp_i,
  input  logic [tfpc_pkg::SetpointW-1:0] setpoint_i,
  input  tfpc_pkg::duty_cfg_t            cfg_i,
  output logic [tfpc_pkg::CompareW-1:0]  compare_o
);

  logic [tfpc_pkg::TempW-1:0]                        diff;
  logic [tfpc_pkg::TicksW-1:0]                       ticks;
  logic [tfpc_pkg::PerTickW+tfpc_pkg::TicksW-1:0]    prod;
  logic [tfpc_pkg::CompareW:0]                       sum;

  always_comb begin
    diff  = temp_i - {1'b0, setpoint_i};
    if (diff >= tfpc_pkg::DiffSat) begin
      ticks = tfpc_pkg::TicksMax;
    end else begin
      ticks = {2'b00, diff[3:0]} + {diff[3:0], 2'b00};
    end
    prod = cfg_i.per_tick * ticks;
    sum  = {1'b0, cfg_i.base} + {1'b0, prod};
    if (temp_i < {1'b0, setpoint_i}) begin
      compare_o = '0;
    end else if (sum[tfpc_pkg::CompareW]) begin
      compare_o = '1;
    end else begin
      compare_o = sum[tfpc_pkg::CompareW-1:0];
    end
  end

endmodule

FILE: sv/thermostat_fan_pwm_controller_top.sv
// ----------------------------------------------------------------------------
// thermostat_fan_pwm_controller_top
// Thermostat with button-held setpoint and fan PWM compare output.
// ----------------------------------------------------------------------------
// Channel  | Bus          | Fields (low bit first)
// s_axis   | tdata 16 bit | up_pressed, down_pressed, adc_sample[11:0]
// m_axis   | tdata 32 bit | setpoint_deg[6:0], temperature_deg[7:0], fan_compare[15:0]
// cfg      | write only   | 0 hold_count, 1 sensor_gain, 2 base_compare, 3 compare_per_tick
//
// One item per cycle sustained while m_axis accepts; items pass through input,
// temperature and result registers. The sensor multiply sits between the first
// two, the duty multiply between the last two. Reset clears valid flags,
// counters and sets the setpoint to 20. A stall on m_axis backs up through all
// three stages before s_axis_tready drops.
// ----------------------------------------------------------------------------
module thermostat_fan_pwm_controller_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // up_pressed, down_pressed, adc_sample
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,  // setpoint, temperature, compare, 0
  input  logic                          cfg_we_i,
  input  logic [tfpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tfpc_pkg::CfgDataW-1:0] cfg_data_i
);

  logic [tfpc_pkg::HoldW-1:0]    hold_q;
  logic [tfpc_pkg::GainW-1:0]    gain_q;
  tfpc_pkg::duty_cfg_t           duty_cfg_q;

  logic                          a_valid_q, b_valid_q, c_valid_q;
  logic                          a_ready, b_ready, c_ready, a_adv, b_adv;
  tfpc_pkg::btn_t                a_btn_q;
  logic [tfpc_pkg::SampleW-1:0]  a_sample_q;
  logic [tfpc_pkg::SampleW+tfpc_pkg::GainW-1:0] a_prod;
  logic [tfpc_pkg::TempW-1:0]    b_temp_q, c_temp_q;
  logic [tfpc_pkg::SetpointW-1:0] b_sp_q, c_sp_q, sp_next;
  logic [tfpc_pkg::CompareW-1:0] compare, c_cmp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q              <= tfpc_pkg::HoldReset;
      gain_q              <= tfpc_pkg::GainReset;
      duty_cfg_q.base     <= tfpc_pkg::BaseReset;
      duty_cfg_q.per_tick <= tfpc_pkg::PerTickReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tfpc_pkg::RegHoldCount:      hold_q <= cfg_data_i;
        tfpc_pkg::RegSensorGain:     gain_q <= cfg_data_i[tfpc_pkg::GainW-1:0];
        tfpc_pkg::RegBaseCompare:    duty_cfg_q.base <= cfg_data_i;
        tfpc_pkg::RegComparePerTick: duty_cfg_q.per_tick <= cfg_data_i[tfpc_pkg::PerTickW-1:0];
        default: ;
      endcase
    end
  end

  assign c_ready       = !c_valid_q || m_axis_tready;
  assign b_ready       = !b_valid_q || c_ready;
  assign a_ready       = !a_valid_q || b_ready;
  assign b_adv         = b_valid_q && c_ready;
  assign a_adv         = a_valid_q && b_ready;
  assign s_axis_tready = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= s_axis_tvalid;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
      if (c_ready) begin
        c_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && s_axis_tvalid) begin
      a_btn_q.up   <= s_axis_tdata[0];
      a_btn_q.down <= s_axis_tdata[1];
      a_sample_q   <= s_axis_tdata[13:2];
    end
    if (a_adv) begin
      b_temp_q <= a_prod[tfpc_pkg::SampleW+tfpc_pkg::GainW-1:tfpc_pkg::SampleW];
      b_sp_q   <= sp_next;
    end
    if (b_adv) begin
      c_temp_q <= b_temp_q;
      c_sp_q   <= b_sp_q;
      c_cmp_q  <= compare;
    end
  end

  assign a_prod = a_sample_q * gain_q;

  tfpc_hold u_hold (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (a_adv),
    .btn_i        (a_btn_q),
    .hold_count_i (hold_q),
    .setpoint_o   (sp_next)
  );

  tfpc_duty u_duty (
    .temp_i     (b_temp_q),
    .setpoint_i (b_sp_q),
    .cfg_i      (duty_cfg_q),
    .compare_o  (compare)
  );

  assign m_axis_tvalid = c_valid_q;
  assign m_axis_tdata  = {1'b0, c_cmp_q, c_temp_q, c_sp_q};

endmodule

FILE: sim/tb_thermostat_fan_pwm_controller_top.sv
// ----------------------------------------------------------------------------
// tb_thermostat_fan_pwm_controller_top
// Self-checking bench for the thermostat fan PWM controller: button hold
// counting, setpoint limits, temperature scaling and fan compare values are
// predicted in the bench and matched against every output item, under random
// backpressure and source gaps.
// ----------------------------------------------------------------------------
module tb_thermostat_fan_pwm_controller_top;

  localparam logic [6:0] SetpointTop  = 7'd127;
  localparam int unsigned TicksPerDeg = 5;
  localparam int unsigned TicksTop    = 50;
  localparam int unsigned CompareTop  = 65535;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned SettleCycles = 8;

  typedef struct packed {
    logic [6:0]  setpoint;
    logic [7:0]  temperature;
    logic [15:0] compare;
  } fan_reading_t;

  typedef enum logic [2:0] {SeqUp, SeqDown, SeqBoth, SeqQuiet, SeqNoise} press_seq_e;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [15:0]                   s_axis_tdata;   // up_pressed, down_pressed, adc_sample[11:0], zeros
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [31:0]                   m_axis_tdata;   // setpoint[6:0], temperature[7:0], compare[15:0], zero
  logic                          cfg_we_i;
  logic [tfpc_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [tfpc_pkg::CfgDataW-1:0] cfg_data_i;

  logic [15:0] cfg_hold;
  logic [7:0]  cfg_gain;
  logic [15:0] cfg_base;
  logic [9:0]  cfg_per_tick;
  logic [15:0] up_cnt;
  logic [15:0] down_cnt;
  logic        up_seen;
  logic        down_seen;
  logic [6:0]  sp_model;

  fan_reading_t expected_readings[$];
  fan_reading_t head_reading;
  int unsigned  tx_idle_pct;
  int unsigned  rx_idle_pct;
  int unsigned  cycle_cnt;
  int           fail_count;

  thermostat_fan_pwm_controller_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected fan reading %h", m_axis_tdata);
        fail_count++;
      end else begin
        head_reading = expected_readings.pop_front();
        if (m_axis_tdata[6:0] !== head_reading.setpoint) begin
          $error("setpoint_deg: expected %0d, actual %0d",
                 head_reading.setpoint, m_axis_tdata[6:0]);
          fail_count++;
        end
        if (m_axis_tdata[14:7] !== head_reading.temperature) begin
          $error("temperature_deg: expected %0d, actual %0d",
                 head_reading.temperature, m_axis_tdata[14:7]);
          fail_count++;
        end
        if (m_axis_tdata[30:15] !== head_reading.compare) begin
          $error("fan_compare: expected %0d, actual %0d",
                 head_reading.compare, m_axis_tdata[30:15]);
          fail_count++;
        end
      end
    end
  end

  function automatic logic advance_hold(inout logic [15:0] cnt, inout logic seen,
                                        input logic pressed);
    logic fire;
    fire = 1'b0;
    if (!pressed) cnt = '0;
    else if (seen) cnt = cnt + 16'd1;
    if (cfg_hold != '0 && cnt == cfg_hold) begin
      cnt  = '0;
      fire = 1'b1;
    end
    seen = pressed;
    return fire;
  endfunction

  function automatic fan_reading_t predict_reading(input logic up_b, input logic down_b,
                                                   input logic [11:0] smp);
    fan_reading_t r;
    logic         step_up;
    logic         step_down;
    int unsigned  temp_v;
    int unsigned  diff;
    int unsigned  duty_ticks;
    int unsigned  cmp;
    step_up   = advance_hold(up_cnt, up_seen, up_b);
    step_down = advance_hold(down_cnt, down_seen, down_b);
    if (step_up && sp_model < SetpointTop) sp_model++;
    if (step_down && sp_model > 7'd0) sp_model--;
    temp_v = (32'(smp) * 32'(cfg_gain)) >> 12;
    if (temp_v < 32'(sp_model)) begin
      cmp = 0;
    end else begin
      diff       = temp_v - 32'(sp_model);
      duty_ticks = (diff * TicksPerDeg > TicksTop) ? TicksTop : diff * TicksPerDeg;
      cmp        = 32'(cfg_base) + 32'(cfg_per_tick) * duty_ticks;
      if (cmp > CompareTop) cmp = CompareTop;
    end
    r.setpoint    = sp_model;
    r.temperature = temp_v[7:0];
    r.compare     = cmp[15:0];
    return r;
  endfunction

  function automatic logic [11:0] sample_for_temp(input int t);
    int unsigned s;
    if (t < 0) t = 0;
    if (cfg_gain == '0) return 12'($urandom_range(4095));
    s = (32'(t) * 4096 + 32'(cfg_gain) - 1) / 32'(cfg_gain);
    if (s > 4095) s = 4095;
    return s[11:0];
  endfunction

  function automatic logic [11:0] pick_sample();
    if ($urandom_range(1) == 0) return 12'($urandom_range(4095));
    return sample_for_temp(int'(sp_model) + int'($urandom_range(14)) - 3);
  endfunction

  task automatic send_sample(input logic up_b, input logic down_b, input logic [11:0] smp);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, smp, down_b, up_b};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_readings.push_back(predict_reading(up_b, down_b, smp));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [tfpc_pkg::CfgIdxW-1:0] idx,
                           input logic [tfpc_pkg::CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [15:0] hold, input logic [7:0] gain,
                            input logic [15:0] base, input logic [9:0] per_tick);
    wait_drained();
    write_reg(tfpc_pkg::RegHoldCount, hold);
    write_reg(tfpc_pkg::RegSensorGain, 16'(gain));
    write_reg(tfpc_pkg::RegBaseCompare, base);
    write_reg(tfpc_pkg::RegComparePerTick, 16'(per_tick));
    cfg_we_i     <= 1'b0;
    cfg_hold     = hold;
    cfg_gain     = gain;
    cfg_base     = base;
    cfg_per_tick = per_tick;
  endtask

  task automatic set_random_config();
    logic [15:0] hold;
    logic [7:0]  gain;
    logic [15:0] base;
    hold = ($urandom_range(9) < 8) ? 16'($urandom_range(1, 6)) : 16'($urandom_range(1, 65535));
    gain = ($urandom_range(9) == 0) ? 8'd255 : 8'($urandom_range(255));
    base = ($urandom_range(1) == 0) ? 16'($urandom_range(8000)) : 16'($urandom_range(65535));
    set_config(hold, gain, base, 10'($urandom_range(1023)));
  endtask

  task automatic test_reset_values();
    send_sample(1'b0, 1'b0, 12'd0);
    send_sample(1'b1, 1'b1, 12'd4095);
    send_sample(1'b0, 1'b0, 12'hAAA);
  endtask

  task automatic test_register_extremes();
    set_config(16'd1, 8'd255, 16'd65535, 10'd1023);
    send_sample(1'b0, 1'b0, 12'd4095);
    send_sample(1'b0, 1'b0, 12'd0);
    set_config(16'd1, 8'd0, 16'd0, 10'd0);
    send_sample(1'b0, 1'b0, 12'd4095);
    set_config(16'd65535, tfpc_pkg::GainReset, 16'd0, 10'd1023);
    send_sample(1'b0, 1'b0, sample_for_temp(int'(sp_model)));
    send_sample(1'b0, 1'b0, sample_for_temp(int'(sp_model) + 1));
    send_sample(1'b0, 1'b0, sample_for_temp(int'(sp_model) + 9));
    send_sample(1'b0, 1'b0, sample_for_temp(int'(sp_model) + 10));
    send_sample(1'b0, 1'b0, sample_for_temp(int'(sp_model) - 1));
  endtask

  task automatic test_hold_rules();
    set_config(16'd0, tfpc_pkg::GainReset, tfpc_pkg::BaseReset, tfpc_pkg::PerTickReset);
    repeat (3) send_sample(1'b1, 1'b1, pick_sample());
    send_sample(1'b0, 1'b0, pick_sample());
    set_config(16'd6, tfpc_pkg::GainReset, tfpc_pkg::BaseReset, tfpc_pkg::PerTickReset);
    repeat (4) send_sample(1'b1, 1'b0, pick_sample());
    set_config(16'd2, tfpc_pkg::GainReset, tfpc_pkg::BaseReset, tfpc_pkg::PerTickReset);
    repeat (4) send_sample(1'b1, 1'b0, pick_sample());
    send_sample(1'b0, 1'b0, pick_sample());
    set_config(16'd65535, tfpc_pkg::GainReset, tfpc_pkg::BaseReset, tfpc_pkg::PerTickReset);
    send_sample(1'b0, 1'b1, pick_sample());
    send_sample(1'b0, 1'b1, pick_sample());
  endtask

  task automatic test_setpoint_limits();
    set_config(16'd1, tfpc_pkg::GainReset, tfpc_pkg::BaseReset, tfpc_pkg::PerTickReset);
    repeat (112) send_sample(1'b1, 1'b0, pick_sample());
    repeat (3) send_sample(1'b1, 1'b1, pick_sample());
    repeat (132) send_sample(1'b0, 1'b1, pick_sample());
    repeat (3) send_sample(1'b1, 1'b1, pick_sample());
  endtask

  task automatic test_random_traffic(input int unsigned n_items, input int unsigned tx_pct,
                                     input int unsigned rx_pct);
    int unsigned sent;
    int unsigned next_cfg;
    int unsigned run_len;
    int unsigned roll;
    press_seq_e  seq;
    logic        up_b;
    logic        down_b;
    sent        = 0;
    next_cfg    = 0;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    while (sent < n_items) begin
      if (sent >= next_cfg) begin
        set_random_config();
        next_cfg = sent + 75;
      end
      roll = $urandom_range(9);
      seq  = (roll < 3) ? SeqUp : (roll < 6) ? SeqDown : (roll == 6) ? SeqBoth :
             (roll == 7) ? SeqQuiet : SeqNoise;
      run_len = $urandom_range(1, (cfg_hold < 16'd12) ? 3 * int'(cfg_hold) + 3 : 12);
      repeat (run_len) begin
        case (seq)
          SeqUp: begin
            up_b = 1'b1; down_b = 1'b0;
          end
          SeqDown: begin
            up_b = 1'b0; down_b = 1'b1;
          end
          SeqBoth: begin
            up_b = 1'b1; down_b = 1'b1;
          end
          SeqQuiet: begin
            up_b = 1'b0; down_b = 1'b0;
          end
          default: begin
            up_b = 1'($urandom_range(1)); down_b = 1'($urandom_range(1));
          end
        endcase
        send_sample(up_b, down_b, pick_sample());
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = tfpc_pkg::RegHoldCount;
    cfg_data_i    = '0;
    cycle_cnt     = 0;
    fail_count    = 0;
    tx_idle_pct   = 29;
    rx_idle_pct   = 82;
    cfg_hold      = tfpc_pkg::HoldReset;
    cfg_gain      = tfpc_pkg::GainReset;
    cfg_base      = tfpc_pkg::BaseReset;
    cfg_per_tick  = tfpc_pkg::PerTickReset;
    up_cnt        = '0;
    down_cnt      = '0;
    up_seen       = 1'b0;
    down_seen     = 1'b0;
    sp_model      = tfpc_pkg::SetpointReset;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_values();
    test_register_extremes();
    test_hold_rules();
    test_setpoint_limits();
    test_random_traffic(150, 29, 82);
    test_random_traffic(150, 82, 29);
    test_random_traffic(150, 0, 0);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0 && expected_readings.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/tfpc_pkg.sv
sv/tfpc_hold.sv
sv/tfpc_duty.sv
sv/thermostat_fan_pwm_controller_top.sv
sim/tb_thermostat_fan_pwm_controller_top.sv
